@@ sv/im2col_pkg.sv @@
`timescale 1ns / 1ps
// im2col_pkg: shared widths, configuration and walk record types.
// Used by every module of the im2col address generator; no dependencies.
package im2col_pkg;

    localparam int DIM_BITS     = 16;
    localparam int OFFSET_BITS  = 32;
    localparam int INDEX_BITS   = 32;
    localparam int DATA_BITS    = 32;
    localparam int REG_IDX_BITS = 4;
    localparam int PROD_BITS    = 2 * DIM_BITS;
    localparam int COORD_BITS   = 2 * DIM_BITS + 2;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef logic [DIM_BITS-1:0]    dim_t;
    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [INDEX_BITS-1:0]  index_t;
    typedef logic [PROD_BITS-1:0]   prod_t;
    typedef logic [COORD_BITS-1:0]  coord_t;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_KERNEL_SIZE   = 4'd0,
        REG_IMAGE_SIZE    = 4'd1,
        REG_OUTPUT_SIZE   = 4'd2,
        REG_CHANNEL_COUNT = 4'd3,
        REG_BATCH_COUNT   = 4'd4,
        REG_STRIDE_XY     = 4'd5,
        REG_PADDING_XY    = 4'd6,
        REG_DILATION_XY   = 4'd7
    } reg_idx_e;

    // Loop limits are kept at least 1; image size is kept as written.
    typedef struct packed {
        dim_t kw;
        dim_t kh;
        dim_t ow;
        dim_t oh;
        dim_t nc;
        dim_t nb;
        dim_t iw;
        dim_t ih;
        dim_t sx;
        dim_t sy;
        dim_t px;
        dim_t py;
        dim_t dx;
        dim_t dy;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        kw: DIM_BITS'(16),  kh: DIM_BITS'(16),
        ow: DIM_BITS'(14),  oh: DIM_BITS'(14),
        nc: DIM_BITS'(3),   nb: DIM_BITS'(1),
        iw: DIM_BITS'(224), ih: DIM_BITS'(224),
        sx: DIM_BITS'(16),  sy: DIM_BITS'(16),
        px: DIM_BITS'(0),   py: DIM_BITS'(0),
        dx: DIM_BITS'(1),   dy: DIM_BITS'(1)
    };

    typedef struct packed {
        dim_t batch;
        dim_t grid_row;
        dim_t grid_col;
        dim_t chan;
        dim_t kernel_row;
        dim_t kernel_col;
    } pos_t;

    typedef struct packed {
        index_t index;
        pos_t   pos;
        logic   last;
    } walk_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

@@ sv/im2col_cfg_regs.sv @@
`timescale 1ns / 1ps
// im2col_cfg_regs: configuration register file, decoded into cfg_t.
// Depends on im2col_pkg.
module im2col_cfg_regs
    import im2col_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [REG_IDX_BITS-1:0] cfg_index,
    input  logic [DATA_BITS-1:0]    cfg_data,
    output cfg_t                    cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    dim_t lo;
    dim_t hi;

    function automatic dim_t at_least_one(input dim_t v);
        return (v == '0) ? DIM_BITS'(1) : v;
    endfunction

    assign cfg_ready = 1'b1;
    assign lo = DIM_BITS'(cfg_data[15:0]);
    assign hi = DIM_BITS'(cfg_data[31:16]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (reg_idx_e'(cfg_index))
                REG_KERNEL_SIZE:
                begin
                    cfg_next.kw = at_least_one(lo);
                    cfg_next.kh = at_least_one(hi);
                end
                REG_IMAGE_SIZE:
                begin
                    cfg_next.iw = lo;
                    cfg_next.ih = hi;
                end
                REG_OUTPUT_SIZE:
                begin
                    cfg_next.ow = at_least_one(lo);
                    cfg_next.oh = at_least_one(hi);
                end
                REG_CHANNEL_COUNT: cfg_next.nc = at_least_one(lo);
                REG_BATCH_COUNT:   cfg_next.nb = at_least_one(lo);
                REG_STRIDE_XY:
                begin
                    cfg_next.sx = lo;
                    cfg_next.sy = hi;
                end
                REG_PADDING_XY:
                begin
                    cfg_next.px = lo;
                    cfg_next.py = hi;
                end
                REG_DILATION_XY:
                begin
                    cfg_next.dx = lo;
                    cfg_next.dy = hi;
                end
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/im2col_walker.sv @@
`timescale 1ns / 1ps
// im2col_walker: front end; takes requests, steps the nested position counters
// and pushes one walk record per request. Depends on im2col_pkg.
module im2col_walker
    import im2col_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   item_valid,
    output logic   item_ready,
    input  logic   restart,
    input  qstat_t qstat,
    output logic   push,
    output walk_t  rec
);

    pos_t   pos_reg;
    pos_t   pos_next;
    index_t idx_reg;
    index_t idx_next;
    pos_t   cur;
    index_t cur_idx;
    logic   e0, e1, e2, e3, e4, e5;
    logic   c1, c2, c3, c4, c5, c6;

    // counter at or past the end of a range of n (n >= 1)
    function automatic logic at_end(input dim_t c, input dim_t n);
        return c >= (n - DIM_BITS'(1));
    endfunction

    assign item_ready = !qstat.full;
    assign push       = item_valid && item_ready;

    assign cur     = restart ? '0 : pos_reg;
    assign cur_idx = restart ? '0 : idx_reg;

    assign e0 = at_end(cur.kernel_col, cfg.kw);
    assign e1 = at_end(cur.kernel_row, cfg.kh);
    assign e2 = at_end(cur.chan,       cfg.nc);
    assign e3 = at_end(cur.grid_col,   cfg.ow);
    assign e4 = at_end(cur.grid_row,   cfg.oh);
    assign e5 = at_end(cur.batch,      cfg.nb);

    assign c1 = e0;
    assign c2 = c1 && e1;
    assign c3 = c2 && e2;
    assign c4 = c3 && e3;
    assign c5 = c4 && e4;
    assign c6 = c5 && e5;

    assign rec.index = cur_idx;
    assign rec.pos   = cur;
    assign rec.last  = c6;

    always_comb
    begin
        pos_next = cur;
        pos_next.kernel_col = e0 ? '0 : cur.kernel_col + DIM_BITS'(1);
        if (c1)
            pos_next.kernel_row = e1 ? '0 : cur.kernel_row + DIM_BITS'(1);
        if (c2)
            pos_next.chan = e2 ? '0 : cur.chan + DIM_BITS'(1);
        if (c3)
            pos_next.grid_col = e3 ? '0 : cur.grid_col + DIM_BITS'(1);
        if (c4)
            pos_next.grid_row = e4 ? '0 : cur.grid_row + DIM_BITS'(1);
        if (c5)
            pos_next.batch = e5 ? '0 : cur.batch + DIM_BITS'(1);
        idx_next = c6 ? '0 : cur_idx + INDEX_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            idx_reg <= '0;
        end
        else if (push)
        begin
            pos_reg <= pos_next;
            idx_reg <= idx_next;
        end
    end

endmodule

@@ sv/im2col_queue.sv @@
`timescale 1ns / 1ps
// im2col_queue: short FIFO of walk records between walker and address pipe.
// Depends on im2col_pkg.
module im2col_queue
    import im2col_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  walk_t  wr_rec,
    input  logic   pop,
    output walk_t  head,
    output qstat_t qstat
);

    walk_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;

    assign qstat.full  = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_BITS'(1);
            2'b01:   count_next = count_reg - QCNT_BITS'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            count_reg <= count_next;
        end
    end

endmodule

@@ sv/im2col_addr_pipe.sv @@
`timescale 1ns / 1ps
// im2col_addr_pipe: back end; four-stage pipe from walk record to source
// coordinates, padding flag and dense offset. Depends on im2col_pkg.
module im2col_addr_pipe
    import im2col_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  walk_t   head,
    input  qstat_t  qstat,
    output logic    pop,
    output logic    result_valid,
    input  logic    result_ready,
    output index_t  element_index,
    output offset_t source_offset,
    output logic    is_padding,
    output logic    last_element
);

    logic    adv;
    logic    v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1: products
    prod_t   gx_reg, kx_reg, gy_reg, ky_reg, bn_reg;
    dim_t    ch1_reg;
    index_t  idx1_reg;
    logic    last1_reg;

    // stage 2: coordinates, channel plane
    coord_t  x2_reg, y2_reg;
    offset_t t1_reg;
    index_t  idx2_reg;
    logic    last2_reg;

    // stage 3: padding test, row offset
    logic    pad3_reg;
    dim_t    x3_reg;
    offset_t t2_reg;
    index_t  idx3_reg;
    logic    last3_reg;

    // stage 4: result register
    offset_t off4_reg;
    logic    pad4_reg;
    index_t  idx4_reg;
    logic    last4_reg;

    coord_t  x_next, y_next;
    logic    x_out, y_out, pad_next;
    offset_t t1_next, t2_next, t3_next;

    assign adv = !v4_reg || result_ready;
    assign pop = adv && !qstat.empty;

    assign x_next = coord_t'(gx_reg) + coord_t'(kx_reg) - coord_t'(cfg.px);
    assign y_next = coord_t'(gy_reg) + coord_t'(ky_reg) - coord_t'(cfg.py);
    assign t1_next = offset_t'(bn_reg) + offset_t'(ch1_reg);

    assign x_out = x2_reg[COORD_BITS-1] ||
                   (x2_reg[COORD_BITS-2:0] >= (COORD_BITS-1)'(cfg.iw));
    assign y_out = y2_reg[COORD_BITS-1] ||
                   (y2_reg[COORD_BITS-2:0] >= (COORD_BITS-1)'(cfg.ih));
    assign pad_next = x_out || y_out;
    assign t2_next = t1_reg * offset_t'(cfg.ih) + offset_t'(y2_reg[DIM_BITS-1:0]);

    assign t3_next = t2_reg * offset_t'(cfg.iw) + offset_t'(x3_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gx_reg    <= prod_t'(head.pos.grid_col) * prod_t'(cfg.sx);
            kx_reg    <= prod_t'(head.pos.kernel_col) * prod_t'(cfg.dx);
            gy_reg    <= prod_t'(head.pos.grid_row) * prod_t'(cfg.sy);
            ky_reg    <= prod_t'(head.pos.kernel_row) * prod_t'(cfg.dy);
            bn_reg    <= prod_t'(head.pos.batch) * prod_t'(cfg.nc);
            ch1_reg   <= head.pos.chan;
            idx1_reg  <= head.index;
            last1_reg <= head.last;

            x2_reg    <= x_next;
            y2_reg    <= y_next;
            t1_reg    <= t1_next;
            idx2_reg  <= idx1_reg;
            last2_reg <= last1_reg;

            pad3_reg  <= pad_next;
            x3_reg    <= x2_reg[DIM_BITS-1:0];
            t2_reg    <= t2_next;
            idx3_reg  <= idx2_reg;
            last3_reg <= last2_reg;

            off4_reg  <= pad3_reg ? '0 : t3_next;
            pad4_reg  <= pad3_reg;
            idx4_reg  <= idx3_reg;
            last4_reg <= last3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= pop;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign result_valid  = v4_reg;
    assign element_index = idx4_reg;
    assign source_offset = off4_reg;
    assign is_padding    = pad4_reg;
    assign last_element  = last4_reg;

endmodule

@@ sv/im2col_address_generator_core.sv @@
`timescale 1ns / 1ps
// im2col_address_generator_core: top level; im2col walk over a dense image.
// Each accepted request passes through the queue and the address pipe before its result is valid.
// Throughput: one request and one result per cycle; a 4-entry queue and the
// 4-stage address pipe absorb output stalls, and requests are held off when full.
// Reset: asynchronous, active low; clears the walk position (next is element 0),
// empties queue and pipe, loads default configuration.
module im2col_address_generator_core
    import im2col_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [REG_IDX_BITS-1:0] cfg_index,
    input  logic [DATA_BITS-1:0]    cfg_data,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  logic                    restart,
    output logic                    result_valid,
    input  logic                    result_ready,
    output logic [INDEX_BITS-1:0]   element_index,
    output logic [OFFSET_BITS-1:0]  source_offset,
    output logic                    is_padding,
    output logic                    last_element
);

    cfg_t   cfg;
    qstat_t qstat;
    logic   push;
    logic   pop;
    walk_t  wr_rec;
    walk_t  head;

    im2col_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    im2col_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .restart    (restart),
        .qstat      (qstat),
        .push       (push),
        .rec        (wr_rec)
    );

    im2col_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_rec (wr_rec),
        .pop    (pop),
        .head   (head),
        .qstat  (qstat)
    );

    im2col_addr_pipe u_pipe (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .head          (head),
        .qstat         (qstat),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .element_index (element_index),
        .source_offset (source_offset),
        .is_padding    (is_padding),
        .last_element  (last_element)
    );

endmodule

@@ sv/im2col_checker.sv @@
`timescale 1ns / 1ps
// im2col_checker: port-level assertions for im2col_address_generator_core,
// attached by bind. Depends on im2col_pkg.
module im2col_checker
    import im2col_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   item_valid,
    input logic                   item_ready,
    input logic                   result_valid,
    input logic                   result_ready,
    input logic [INDEX_BITS-1:0]  element_index,
    input logic [OFFSET_BITS-1:0] source_offset,
    input logic                   is_padding,
    input logic                   last_element
);

    logic       item_take;
    logic       result_take;
    logic [3:0] outstanding_reg;
    logic [3:0] outstanding_next;

    assign item_take   = item_valid && item_ready;
    assign result_take = result_valid && result_ready;

    // requests accepted and not yet delivered; queue plus pipe hold at most 8
    assign outstanding_next = outstanding_reg + 4'(item_take) - 4'(result_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outstanding_reg <= '0;
        else
            outstanding_reg <= outstanding_next;
    end

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(element_index)
            && $stable(source_offset) && $stable(is_padding) && $stable(last_element))
        else $error("result changed while stalled");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && is_padding |-> source_offset == '0)
        else $error("padding result with nonzero offset");

    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !result_valid)
        else $error("result present right after reset");

    // every result belongs to an accepted request
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> outstanding_reg != '0)
        else $error("result without an outstanding request");

endmodule

bind im2col_address_generator_core im2col_checker u_im2col_checker (.*);
